// ----- rtl/rrq_pkg.sv -----
// ---------------------------------------------------------------------------
// rrq_pkg
// Command and status codes shared by the round-robin ready queue and its
// checker.
// ---------------------------------------------------------------------------
`default_nettype none

package rrq_pkg;

   localparam int CMD_W    = 2;
   localparam int TASK_W   = 3;
   localparam int STATUS_W = 2;

   typedef logic [CMD_W-1:0]    command_type;
   typedef logic [TASK_W-1:0]   task_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam command_type CMD_ADD    = 2'd0;
   localparam command_type CMD_REMOVE = 2'd1;
   localparam command_type CMD_NEXT   = 2'd2;

   localparam status_type ST_DONE      = 2'd0;
   localparam status_type ST_EMPTY     = 2'd1;
   localparam status_type ST_NOT_FOUND = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/rrq_req_if.sv -----
// ---------------------------------------------------------------------------
// rrq_req_if
// Request channel of the ready queue: command and task number.
// ---------------------------------------------------------------------------
`default_nettype none

interface rrq_req_if
   import rrq_pkg::*;
   ();

   logic        valid;
   logic        ready;
   command_type command;
   task_type    task_id;

   modport source (output valid, output command, output task_id, input ready);
   modport sink   (input valid, input command, input task_id, output ready);

endinterface

`default_nettype wire

// ----- rtl/rrq_rsp_if.sv -----
// ---------------------------------------------------------------------------
// rrq_rsp_if
// Response channel of the ready queue: returned task and status.
// ---------------------------------------------------------------------------
`default_nettype none

interface rrq_rsp_if
   import rrq_pkg::*;
   ();

   logic       valid;
   logic       ready;
   task_type   next_task;
   status_type status;

   modport source (output valid, output next_task, output status, input ready);
   modport sink   (input valid, input next_task, input status, output ready);

endinterface

`default_nettype wire

// ----- rtl/round_robin_ready_queue.sv -----
// ---------------------------------------------------------------------------
// round_robin_ready_queue
// Round-robin ready queue of task numbers, held as a ring in a successor
// table with a head pointer and an empty flag. A small sequencer walks the
// ring one successor read per cycle; the table has a read and a write port.
// ---------------------------------------------------------------------------
//   channel   dir   handshake            payload
//   req_bus   in    valid / ready        command, task_id
//   rsp_bus   out   valid / ready        next_task, status
//
// Next: acceptance, then ADVANCE and REPLY, then the registered response.
// Add and remove on a non-empty queue walk the ring in WALK, one successor
// table read per cycle, then reach REPLY (via LINK_NEW or UNLINK to relink).
// Empty queue, bad task number, unused command: IDLE goes straight to REPLY.
// Reset clears the head to 0 and marks the queue empty; the table is not
// cleared. req_bus.ready is low from acceptance until the response is
// registered; a held response stalls the sequencer in its reply step.
// ---------------------------------------------------------------------------
`default_nettype none

module round_robin_ready_queue
   import rrq_pkg::*;
#(
   parameter int NUM_TASKS = 8
) (
   input  wire      clock,
   input  wire      reset,
   rrq_req_if.sink   req_bus,
   rrq_rsp_if.source rsp_bus
);

   localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int SW = $clog2(NUM_TASKS + 1);

   typedef enum logic [2:0] {
      IDLE,
      WALK,
      LINK_NEW,
      UNLINK,
      ADVANCE,
      REPLY
   } state_type;

   typedef logic [TW-1:0] index_type;

   // successor table
   index_type succ_mem [NUM_TASKS];
   index_type rd_data_ff;
   index_type rd_addr;
   logic      wr_en;
   index_type wr_addr;
   index_type wr_data;

   state_type   state_ff,      state_in;
   command_type op_ff,         op_in;
   index_type   task_ff,       task_in;
   index_type   cur_ff,        cur_in;
   logic [SW-1:0] steps_ff,    steps_in;
   index_type   head_ff,       head_in;
   logic        empty_ff,      empty_in;
   task_type    res_task_ff,   res_task_in;
   status_type  res_status_ff, res_status_in;
   logic        rsp_valid_ff,  rsp_valid_in;
   task_type    rsp_task_ff,   rsp_task_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic      accept;
   logic      id_ok;
   index_type req_idx;
   logic      walk_more;
   logic      out_free;

   assign req_bus.ready     = (state_ff == IDLE);
   assign accept            = req_bus.valid && req_bus.ready;
   assign id_ok             = 32'(req_bus.task_id) < NUM_TASKS;
   assign req_idx           = TW'(req_bus.task_id);
   assign out_free          = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.next_task = rsp_task_ff;
   assign rsp_bus.status    = rsp_status_ff;

   // add stops at the tail; remove also stops at the task's predecessor
   always_comb begin
      walk_more = (steps_ff < SW'(NUM_TASKS)) && (rd_data_ff != head_ff);
      if (op_ff == CMD_REMOVE) begin
         walk_more = walk_more && (rd_data_ff != task_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      task_in       = task_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      head_in       = head_ff;
      empty_in      = empty_ff;
      res_task_in   = res_task_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_task_in   = rsp_task_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = head_ff;
      wr_en         = 1'b0;
      wr_addr       = task_ff;
      wr_data       = head_ff;

      case (state_ff)
         IDLE: begin
            if (accept) begin
               op_in         = req_bus.command;
               task_in       = req_idx;
               cur_in        = head_ff;
               steps_in      = '0;
               res_task_in   = '0;
               res_status_in = ST_DONE;
               state_in      = REPLY;
               case (req_bus.command)
                  CMD_ADD: begin
                     if (!id_ok) begin
                        res_status_in = ST_NOT_FOUND;
                     end else if (empty_ff) begin
                        wr_en    = 1'b1;
                        wr_addr  = req_idx;
                        wr_data  = req_idx;
                        head_in  = req_idx;
                        empty_in = 1'b0;
                     end else begin
                        state_in = WALK;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!id_ok) begin
                        res_status_in = ST_NOT_FOUND;
                     end else if (empty_ff) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        state_in = WALK;
                     end
                  end
                  CMD_NEXT: begin
                     if (empty_ff) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        state_in = ADVANCE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         WALK: begin
            if (op_ff == CMD_REMOVE && steps_ff == '0 && head_ff == task_ff &&
                rd_data_ff == head_ff) begin
               // sole task leaves the ring
               empty_in = 1'b1;
               state_in = REPLY;
            end else if (walk_more) begin
               cur_in   = rd_data_ff;
               steps_in = steps_ff + 1'b1;
               rd_addr  = rd_data_ff;
            end else if (op_ff == CMD_ADD) begin
               wr_en    = 1'b1;
               wr_addr  = cur_ff;
               wr_data  = task_ff;
               state_in = LINK_NEW;
            end else if (rd_data_ff != task_ff) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = REPLY;
            end else begin
               rd_addr  = task_ff;
               state_in = UNLINK;
            end
         end

         LINK_NEW: begin
            wr_en    = 1'b1;
            wr_addr  = task_ff;
            wr_data  = head_ff;
            state_in = REPLY;
         end

         UNLINK: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = rd_data_ff;
            if (task_ff == head_ff) begin
               head_in = rd_data_ff;
            end
            state_in = REPLY;
         end

         ADVANCE: begin
            res_task_in = TASK_W'(head_ff);
            head_in     = rd_data_ff;
            state_in    = REPLY;
         end

         REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_task_in   = res_task_ff;
               rsp_status_in = res_status_ff;
               state_in      = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         succ_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= succ_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         head_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      task_ff       <= task_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      res_task_ff   <= res_task_in;
      res_status_ff <= res_status_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

`default_nettype wire

// ----- rtl/rrq_checker.sv -----
// ---------------------------------------------------------------------------
// rrq_checker
// Port-level checks on the ready queue, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module rrq_checker
   import rrq_pkg::*;
(
   input wire             clock,
   input wire             reset,
   input wire             req_valid,
   input wire             req_ready,
   input wire             rsp_valid,
   input wire             rsp_ready,
   input wire task_type   rsp_next_task,
   input wire status_type rsp_status
);

   // no response survives reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request in flight: ready drops once a request is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // a returned task only comes with a done status
   a_task_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_next_task == '0)
      else $error("task returned with a failing status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_task) &&
                                  $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind round_robin_ready_queue rrq_checker u_rrq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_next_task (rsp_bus.next_task),
   .rsp_status    (rsp_bus.status)
);

`default_nettype wire
